// ===== sv/kls_pkg.sv =====
// Shared types, constants and keyword tables of the keyword lexer.
`timescale 1ns / 1ps
`default_nettype none
package kls_pkg;

   localparam int KW_COUNT    = 7;
   localparam int KW_MAX      = 8;
   localparam int LEN_BITS    = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCOUNT_BITS = 3;

   typedef enum logic [2:0] {
      TOK_VARIABLE = 3'd0,
      TOK_NUMBER   = 3'd1,
      TOK_OPERATOR = 3'd2,
      TOK_PUNCT    = 3'd3,
      TOK_STRING   = 3'd4,
      TOK_KEYWORD  = 3'd5
   } token_kind_type;

   typedef enum logic [2:0] {
      CLS_SEPARATOR = 3'd0,
      CLS_LETTER    = 3'd1,
      CLS_DIGIT     = 3'd2,
      CLS_OPERATOR  = 3'd3,
      CLS_PUNCT     = 3'd4,
      CLS_QUOTE     = 3'd5
   } char_class_type;

   typedef struct packed {
      logic           end_of_text;
      char_class_type cls;
      logic [7:0]     ch;
   } lex_item_type;

   typedef struct packed {
      logic pop;
      logic emit;
   } back_status_type;

   // Keyword text, left justified, zero padded.
   function automatic logic [8*KW_MAX-1:0] kw_word(input logic [2:0] k);
      logic [8*KW_MAX-1:0] w;
      case (k)
         3'd0:    w = "function";
         3'd1:    w = {"end", 40'h0};
         3'd2:    w = {"print", 24'h0};
         3'd3:    w = {"type", 32'h0};
         3'd4:    w = {"true", 32'h0};
         3'd5:    w = {"false", 24'h0};
         3'd6:    w = {"while", 24'h0};
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] kw_len(input logic [2:0] k);
      logic [3:0] n;
      case (k)
         3'd0:    n = 4'd8;
         3'd1:    n = 4'd3;
         3'd2:    n = 4'd5;
         3'd3:    n = 4'd4;
         3'd4:    n = 4'd4;
         3'd5:    n = 4'd5;
         3'd6:    n = 4'd5;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
      logic [8*KW_MAX-1:0] w;
      logic [2:0]          sel;
      w   = kw_word(k);
      sel = 3'd7 - idx;
      return w[{sel, 3'b000} +: 8];
   endfunction

endpackage
`default_nettype wire

// ===== sv/kls_stream_if.sv =====
// Valid/ready channel interfaces for the lexer's character and token streams.
`timescale 1ns / 1ps
`default_nettype none
interface kls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_text;

   modport source (output valid, output ch, output end_of_text, input ready);
   modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface kls_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [2:0]  keyword_id;
   logic [7:0]  first_char;
   logic [15:0] token_start;
   logic [15:0] token_length;

   modport source (output valid, output token_kind, output keyword_id, output first_char,
                   output token_start, output token_length, input ready);
   modport sink   (input valid, input token_kind, input keyword_id, input first_char,
                   input token_start, input token_length, output ready);
endinterface
`default_nettype wire

// ===== sv/kls_front.sv =====
// Front end: accept character beats, classify them and queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module kls_front (
   input  wire                       clock,
   input  wire                       reset,
   kls_req_if.sink                   req_stream,
   input  kls_pkg::back_status_type  status,
   output logic                      item_valid,
   output kls_pkg::lex_item_type     item
);
   import kls_pkg::*;

   lex_item_type               queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0]     count_ff, count_in;
   logic                       push;
   lex_item_type               new_item;
   char_class_type             cls;

   // Classify the incoming byte.
   always_comb begin
      cls = CLS_SEPARATOR;
      if ((req_stream.ch >= "a" && req_stream.ch <= "z") ||
          (req_stream.ch >= "A" && req_stream.ch <= "Z")) begin
         cls = CLS_LETTER;
      end else if (req_stream.ch >= "0" && req_stream.ch <= "9") begin
         cls = CLS_DIGIT;
      end else if (req_stream.ch inside {"-", "+", "*", "/", "%", ">", "<", "="}) begin
         cls = CLS_OPERATOR;
      end else if (req_stream.ch inside {"(", ")", "{", "}", "[", "]", ",", ";", ":"}) begin
         cls = CLS_PUNCT;
      end else if (req_stream.ch == 8'h22 || req_stream.ch == 8'h27) begin
         cls = CLS_QUOTE;
      end
   end

   assign new_item.end_of_text = req_stream.end_of_text;
   assign new_item.cls         = cls;
   assign new_item.ch          = req_stream.ch;

   assign req_stream.ready = (count_ff != QCOUNT_BITS'(QUEUE_DEPTH));
   assign push             = req_stream.valid && req_stream.ready;
   assign item_valid       = (count_ff != '0);
   assign item             = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = status.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !status.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && status.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/kls_back.sv =====
// Back end: token state, keyword match and the registered token output.
`timescale 1ns / 1ps
`default_nettype none
module kls_back #(
   parameter int POSITION_BITS = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       item_valid,
   input  kls_pkg::lex_item_type     item,
   output kls_pkg::back_status_type  status,
   kls_rsp_if.source                 rsp_stream
);
   import kls_pkg::*;

   localparam int WIDE_BITS = (POSITION_BITS > 16) ? POSITION_BITS : 16;

   logic                     in_string_ff, in_string_in;
   logic                     open_ff, open_in;
   token_kind_type           kind_ff, kind_in;
   logic [7:0]               first_ff, first_in;
   logic [LEN_BITS-1:0]      len_ff, len_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [KW_COUNT-1:0]      match_ff, match_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   token_kind_type           rsp_kind_ff;
   logic [2:0]               rsp_id_ff;
   logic [7:0]               rsp_first_ff;
   logic [15:0]              rsp_start_ff;
   logic [15:0]              rsp_len_ff;

   logic                     out_free, emit_req, pop, continue_run, is_quote;
   token_kind_type           item_kind;
   logic [POSITION_BITS-1:0] pos_next;
   logic [WIDE_BITS-1:0]     start_wide;
   logic [15:0]              start_sat;
   logic                     kw_hit;
   logic [2:0]               kw_id;
   logic [7:0]               app_first;
   logic [LEN_BITS-1:0]      app_len;
   logic [KW_COUNT-1:0]      app_match, init_match;

   assign is_quote = (item.cls == CLS_QUOTE);
   assign pos_next = (pos_ff == {POSITION_BITS{1'b1}}) ? pos_ff : pos_ff + 1'b1;

   always_comb begin
      case (item.cls)
         CLS_LETTER:   item_kind = TOK_VARIABLE;
         CLS_DIGIT:    item_kind = TOK_NUMBER;
         CLS_OPERATOR: item_kind = TOK_OPERATOR;
         CLS_PUNCT:    item_kind = TOK_PUNCT;
         default:      item_kind = TOK_STRING;
      endcase
   end

   assign continue_run = open_ff &&
                         (item.cls inside {CLS_LETTER, CLS_DIGIT, CLS_OPERATOR, CLS_PUNCT}) &&
                         (kind_ff == item_kind) &&
                         (item.cls != CLS_PUNCT || item.ch == first_ff);

   // Does this beat close the open token?
   always_comb begin
      if (item.end_of_text) begin
         emit_req = open_ff;
      end else if (in_string_ff) begin
         emit_req = is_quote && open_ff;
      end else begin
         emit_req = open_ff && !continue_run;
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_stream.ready;
   assign pop         = item_valid && (!emit_req || out_free);
   assign status.pop  = pop;
   assign status.emit = emit_req;

   // Keyword detect on the open token; lowest index wins.
   always_comb begin
      kw_hit = 1'b0;
      kw_id  = '0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (match_ff[k] && len_ff == LEN_BITS'(kw_len(3'(k)))) begin
            kw_hit = 1'b1;
            kw_id  = 3'(k);
         end
      end
   end

   assign start_wide = WIDE_BITS'(start_ff);
   assign start_sat  = (start_wide > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF : start_wide[15:0];

   // Append and start-of-token values.
   always_comb begin
      app_first = (len_ff == '0) ? item.ch : first_ff;
      app_len   = (len_ff == {LEN_BITS{1'b1}}) ? len_ff : len_ff + 1'b1;
      for (int k = 0; k < KW_COUNT; k++) begin
         app_match[k]  = match_ff[k];
         if (len_ff < LEN_BITS'(KW_MAX)) begin
            app_match[k] = match_ff[k] && (item.ch == kw_char(3'(k), len_ff[2:0]));
         end
         init_match[k] = (item.ch == kw_char(3'(k), 3'd0));
      end
   end

   always_comb begin
      in_string_in = in_string_ff;
      open_in      = open_ff;
      kind_in      = kind_ff;
      first_in     = first_ff;
      len_in       = len_ff;
      start_in     = start_ff;
      pos_in       = pos_ff;
      match_in     = match_ff;
      if (pop) begin
         pos_in = pos_next;
         if (item.end_of_text) begin
            in_string_in = 1'b0;
            open_in      = 1'b0;
            len_in       = '0;
            start_in     = '0;
            pos_in       = '0;
         end else if (in_string_ff) begin
            if (is_quote) begin
               in_string_in = 1'b0;
               open_in      = 1'b0;
            end else begin
               first_in = app_first;
               len_in   = app_len;
               match_in = app_match;
            end
         end else if (is_quote) begin
            in_string_in = 1'b1;
            open_in      = 1'b1;
            kind_in      = TOK_STRING;
            first_in     = '0;
            len_in       = '0;
            start_in     = pos_next;
         end else if (continue_run) begin
            first_in = app_first;
            len_in   = app_len;
            match_in = app_match;
         end else if (item.cls != CLS_SEPARATOR) begin
            open_in  = 1'b1;
            kind_in  = item_kind;
            first_in = item.ch;
            len_in   = LEN_BITS'(1);
            start_in = pos_ff;
            match_in = init_match;
         end else begin
            open_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_stream.ready;
      if (pop && emit_req) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         open_ff      <= 1'b0;
         len_ff       <= '0;
         start_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_string_ff <= in_string_in;
         open_ff      <= open_in;
         len_ff       <= len_in;
         start_ff     <= start_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      first_ff <= first_in;
      match_ff <= match_in;
      if (pop && emit_req) begin
         rsp_kind_ff  <= (kind_ff == TOK_VARIABLE && kw_hit) ? TOK_KEYWORD : kind_ff;
         rsp_id_ff    <= (kind_ff == TOK_VARIABLE && kw_hit) ? kw_id : 3'd0;
         rsp_first_ff <= first_ff;
         rsp_start_ff <= start_sat;
         rsp_len_ff   <= len_ff;
      end
   end

   assign rsp_stream.valid        = rsp_valid_ff;
   assign rsp_stream.token_kind   = rsp_kind_ff;
   assign rsp_stream.keyword_id   = rsp_id_ff;
   assign rsp_stream.first_char   = rsp_first_ff;
   assign rsp_stream.token_start  = rsp_start_ff;
   assign rsp_stream.token_length = rsp_len_ff;

endmodule
`default_nettype wire

// ===== sv/keyword_lexer_stream.sv =====
// Top level of the streaming keyword lexer: front end, queue and back end.
//
// Usage
//  - req_stream carries one text byte per beat (ch), or an end marker
//    (end_of_text) that flushes any open token and restarts positions at 0.
//  - rsp_stream carries one token per beat: kind, keyword index, first
//    byte, start position and length (both saturating at 65535).
//  - The byte that closes a token is registered in the queue, then the
//    token is registered in the back end's output register and presented.
//  - Throughput, set by the back end's state update, is one byte per clock
//    unless a byte that closes a token waits on a stalled receiver; the
//    keyword match runs incrementally per byte.
//  - A four-entry queue sits between the front and back ends; the back end
//    holds a token in its output register while the receiver stalls and
//    keeps consuming bytes that close no token. Once the queue fills,
//    req_stream.ready drops.
//  - Reset empties the queue, drops any pending token and returns the
//    position counter, token start and length and open flags to zero.
`timescale 1ns / 1ps
`default_nettype none
module keyword_lexer_stream #(
   parameter int POSITION_BITS = 16
) (
   input  wire        clock,
   input  wire        reset,
   kls_req_if.sink    req_stream,
   kls_rsp_if.source  rsp_stream
);
   import kls_pkg::*;

   logic            item_valid;
   lex_item_type    item;
   back_status_type status;

   // Accept, classify and queue incoming bytes.
   kls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .status     (status),
      .item_valid (item_valid),
      .item       (item)
   );

   // Advance the token state and drive the output register.
   kls_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .status     (status),
      .rsp_stream (rsp_stream)
   );

   // A full queue always has a byte to offer the back end.
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !req_stream.ready |-> item_valid)
      else $error("queue full while reporting empty");

   // A popped byte that closes a token must show a token next cycle.
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (status.pop && status.emit) |=> rsp_stream.valid)
      else $error("closed token not presented");

   // Never pop an emitting byte over a stalled output.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_stream.valid && !rsp_stream.ready && status.emit) |-> !status.pop)
      else $error("pending token overwritten");

   // Nothing is offered just after reset.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_stream.valid)
      else $error("token offered after reset");

endmodule
`default_nettype wire
